@@ rtl/capacitive_touch_rc_timer_top_defines.svh @@
// ---------------------------------------------------------------------------
// capacitive_touch_rc_timer_top_defines.svh
// Assertion helpers used by the touch timer RTL.
// ---------------------------------------------------------------------------
`ifndef CAPACITIVE_TOUCH_RC_TIMER_TOP_DEFINES_SVH
`define CAPACITIVE_TOUCH_RC_TIMER_TOP_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define CTRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ctrt_pkg.sv @@
// ---------------------------------------------------------------------------
// ctrt_pkg
// Types and constants of the capacitive touch RC timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctrt_pkg;

    localparam int SAMPLES_W  = 16;
    localparam int TIMEOUT_W  = 28;
    localparam int PERIOD_W   = 32;
    localparam int READING_W  = 28;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(620000);
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = PERIOD_W'(20000);

    // register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_AUTOCAL = 1'b1;

    // receive pin drive codes
    localparam logic [1:0] DRV_RELEASE = 2'd0;
    localparam logic [1:0] DRV_LOW     = 2'd1;
    localparam logic [1:0] DRV_HIGH    = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_DISCHARGE = 5'b00010,
        PH_RISE      = 5'b00100,
        PH_PRECHARGE = 5'b01000,
        PH_FALL      = 5'b10000
    } t_phase;

    // input beat, lowest field last
    typedef struct packed {
        logic [2:0]           pad;
        logic                 recal;
        logic                 ms_tick;
        logic                 recv_level;
        logic                 raw_mode;
        logic [SAMPLES_W-1:0] samples;
        logic                 start_req;
    } t_item;

    // output beat, lowest field last
    typedef struct packed {
        logic [5:0]           pad;
        logic [READING_W-1:0] reading;
        logic                 status;
        logic                 done_res;
        logic                 busy_res;
        logic [1:0]           recv_drive;
        logic                 send_level;
    } t_result;

endpackage

@@ rtl/capacitive_touch_rc_timer_top.sv @@
// ---------------------------------------------------------------------------
// capacitive_touch_rc_timer_top
// RC charge-time touch sensor timer with tracked minimum baseline.
// ---------------------------------------------------------------------------
// Usage:
//   Every input beat on s_* stands for one timer clock of the sensor: receive
//   pin level, ms tick, start request with sample count and mode, recal.
//   Every input beat gives exactly one output beat on m_* carrying the pin
//   drive for that step, busy, and on done the status and reading.
//   Config: write i_cfg_data to register i_cfg_idx (0 timeout count,
//   1 autocal period in ms) with i_cfg_we, only while no measurement runs.
// Timing:
//   One beat per cycle while the receiver keeps m_tready high. Output is valid
//   in the cycle after input accept: the state update and result logic sit
//   between the state registers and the output register; the autocal check
//   is a shift-add compare against 9x/11x the baseline, no divider.
//   s_tready is high when the output register is empty or being drained, so
//   a stalled receiver stalls the input after one beat is held.
// Reset:
//   Synchronous, active low. Phase idle, count zero, baseline full scale,
//   ms counter zero, registers at 620000 / 20000, output register empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module capacitive_touch_rc_timer_top #(
    parameter int COUNT_WIDTH = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // {start_req, samples[15:0], raw_mode, recv_level, ms_tick, recal} from bit 0 up
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ctrt_pkg::IN_DATA_W-1:0]     s_tdata,
    // {send_level, recv_drive[1:0], busy_res, done_res, status, reading[27:0]}
    // from bit 0 up
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ctrt_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [ctrt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ctrt_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int WC = (CW > TIMEOUT_W) ? CW : TIMEOUT_W;
    localparam int MW = CW + 4;
    localparam logic [CW-1:0] FULL = {CW{1'b1}};
    localparam logic [MW-1:0] TEN  = MW'(10);

    // state
    t_phase                r_phase, n_phase;
    logic [CW-1:0]         r_total, n_total;
    logic [SAMPLES_W-1:0]  r_left,  n_left;
    logic                  r_raw,   n_raw;
    logic [CW-1:0]         r_base,  n_base;
    logic [PERIOD_W-1:0]   r_ms,    n_ms;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_out_valid;
    t_result               r_out,   n_out;

    t_item                 item;
    logic                  s_fire;
    logic [CW-1:0]         base_eff;
    logic                  may_count;
    logic                  timed_out;
    logic                  finish;
    logic                  cal;
    logic                  t_ge_b;
    logic                  near;
    logic [MW-1:0]         t_x10, b_x9, b_x11;
    logic [CW-1:0]         diff_tb;
    logic [CW-1:0]         rd;

    assign item     = t_item'(s_tdata);
    assign s_tready = !r_out_valid || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    assign base_eff  = item.recal ? FULL : r_base;
    assign may_count = (WC'(r_total) < WC'(r_timeout)) && (r_total != FULL);
    assign timed_out = WC'(r_total) >= WC'(r_timeout);

    // |t - b| < floor(b/10)  <=>  10*(|t - b| + 1) <= b, split by sign
    assign t_x10   = (MW'(r_total) << 3) + (MW'(r_total) << 1);
    assign b_x9    = (MW'(base_eff) << 3) + MW'(base_eff);
    assign b_x11   = (MW'(base_eff) << 3) + (MW'(base_eff) << 1) + MW'(base_eff);
    assign t_ge_b  = r_total >= base_eff;
    assign near    = t_ge_b ? (t_x10 + TEN <= b_x11) : (b_x9 + TEN <= t_x10);
    assign diff_tb = r_total - base_eff;

    always_comb begin
        n_phase = r_phase;
        n_total = r_total;
        n_left  = r_left;
        n_raw   = r_raw;
        n_base  = base_eff;
        n_out   = '0;
        finish  = 1'b0;
        cal     = 1'b0;
        rd      = '0;

        unique case (r_phase)
            PH_DISCHARGE: begin
                n_out.busy_res   = 1'b1;
                n_out.recv_drive = DRV_LOW;
                n_phase          = PH_RISE;
            end
            PH_RISE: begin
                n_out.busy_res   = 1'b1;
                n_out.send_level = 1'b1;
                if (!item.recv_level && may_count) begin
                    n_total = r_total + CW'(1);
                end else begin
                    n_phase = PH_PRECHARGE;
                end
            end
            PH_PRECHARGE: begin
                n_out.busy_res   = 1'b1;
                n_out.recv_drive = DRV_HIGH;
                n_phase          = PH_FALL;
            end
            PH_FALL: begin
                n_out.busy_res = 1'b1;
                if (item.recv_level && may_count) begin
                    n_total = r_total + CW'(1);
                end else if (timed_out) begin
                    n_out.done_res = 1'b1;
                    n_out.status   = 1'b1;
                    n_phase        = PH_IDLE;
                end else begin
                    // a zero count wraps and keeps going
                    n_left = r_left - SAMPLES_W'(1);
                    if (r_left == SAMPLES_W'(1)) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = PH_DISCHARGE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (item.start_req) begin
                    n_total = '0;
                    if (item.samples == '0) begin
                        n_out.done_res = 1'b1;
                    end else begin
                        n_left  = item.samples;
                        n_raw   = item.raw_mode;
                        n_phase = PH_DISCHARGE;
                    end
                end
            end
        endcase

        if (finish) begin
            n_out.done_res = 1'b1;
            n_phase        = PH_IDLE;
            if (r_raw) begin
                rd = r_total;
            end else begin
                cal = (r_ms > r_period) && near;
                // after a cal the baseline becomes the total itself
                if (cal || !t_ge_b) begin
                    n_base = r_total;
                end
                rd = (!cal && t_ge_b) ? diff_tb : '0;
            end
        end
        n_out.reading = READING_W'(rd);

        if (cal) begin
            n_ms = '0;
        end else if (item.ms_tick && (r_ms != {PERIOD_W{1'b1}})) begin
            n_ms = r_ms + PERIOD_W'(1);
        end else begin
            n_ms = r_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_total     <= '0;
            r_left      <= '0;
            r_raw       <= 1'b0;
            r_base      <= FULL;
            r_ms        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase <= n_phase;
                r_total <= n_total;
                r_left  <= n_left;
                r_raw   <= n_raw;
                r_base  <= n_base;
                r_ms    <= n_ms;
            end
            if (s_tready) begin
                r_out_valid <= s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_period  <= PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_AUTOCAL: r_period  <= i_cfg_data[PERIOD_W-1:0];
                default:     r_period  <= r_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= n_out;
        end
    end

`include "capacitive_touch_rc_timer_top_defines.svh"

    `CTRT_ASSERT(a_start_enters_discharge, i_clk, i_rst_n, (s_fire && r_phase == PH_IDLE && item.start_req && item.samples != '0) |=> (r_phase == PH_DISCHARGE), "nonzero start did not enter discharge")
    `CTRT_ASSERT(a_timeout_reads_zero, i_clk, i_rst_n, (r_out_valid && r_out.done_res && r_out.status) |-> (r_out.reading == '0), "timeout beat carries a reading")
    `CTRT_ASSERT(a_idle_beat_quiet, i_clk, i_rst_n, (r_out_valid && !r_out.done_res) |-> (r_out.reading == '0 && !r_out.status), "non-done beat carries status or reading")
    `CTRT_ASSERT(a_base_held_without_beat, i_clk, i_rst_n, (!s_fire) |=> $stable(r_base), "baseline changed without an input beat")
    `CTRT_ASSERT_ALWAYS(a_empty_out_ready, i_clk, (!r_out_valid) |-> s_tready, "input stalled with empty output register")

endmodule

@@ sim/capacitive_touch_rc_timer_top_tb.sv @@
// ---------------------------------------------------------------------------
// capacitive_touch_rc_timer_top_tb
// Self-checking bench for the RC charge-time touch timer. Every accepted
// input beat is run through a cycle-level predictor of the timer (phases,
// accumulated count, timeout, tracked baseline with autocal) and the output
// beats are checked field by field in order. Directed sequences, each followed
// by random pin activity with measurement starts, run under several register
// settings, with random source/sink throttling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module capacitive_touch_rc_timer_top_tb;

    import ctrt_pkg::*;

    localparam logic [27:0] COUNT_FULL = 28'h0FFFFFFF;

    localparam int GAP_NONE = 0;
    localparam int GAP_SEND = 1;
    localparam int GAP_RECV = 2;
    localparam int GAP_BOTH = 3;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_idx  = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    capacitive_touch_rc_timer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted timer state and register copies
    t_phase      ph       = PH_IDLE;
    logic [27:0] tot      = '0;
    logic [15:0] left     = '0;
    logic        raw_lat  = 1'b0;
    logic [27:0] base     = COUNT_FULL;
    logic [31:0] ms_cnt   = '0;
    logic [27:0] tmo_lim  = 28'd620000;
    logic [31:0] cal_per  = 32'd20000;

    t_item   pend_q[$];
    int      gap_q[$];
    t_result reading_q[$];
    int      beats_queued = 0;
    int      beats_seen   = 0;
    int      err_cnt      = 0;
    int      gap_mode     = GAP_NONE;
    int      drv_gap      = GAP_NONE;
    bit      in_taken     = 1'b0;

    // random pin activity: level runs of random length
    bit      lvl_now      = 1'b0;
    int      run_left     = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit can_count();
        return tot < tmo_lim && tot < COUNT_FULL;
    endfunction

    // one timer clock of the sensor
    task automatic sense_step(input t_item it, output t_result r);
        logic [27:0] diff;
        bit          finish;
        bit          cal;
        r      = '0;
        finish = 1'b0;
        cal    = 1'b0;
        if (it.recal)
            base = COUNT_FULL;
        case (ph)
            PH_DISCHARGE: begin
                r.busy_res   = 1'b1;
                r.recv_drive = DRV_LOW;
                ph = PH_RISE;
            end
            PH_RISE: begin
                r.busy_res   = 1'b1;
                r.send_level = 1'b1;
                if (!it.recv_level && can_count())
                    tot++;
                else
                    ph = PH_PRECHARGE;
            end
            PH_PRECHARGE: begin
                r.busy_res   = 1'b1;
                r.recv_drive = DRV_HIGH;
                ph = PH_FALL;
            end
            PH_FALL: begin
                r.busy_res = 1'b1;
                if (it.recv_level && can_count()) begin
                    tot++;
                end else if (tot >= tmo_lim) begin
                    r.done_res = 1'b1;
                    r.status   = 1'b1;
                    ph = PH_IDLE;
                end else begin
                    left--;
                    if (left == 0)
                        finish = 1'b1;
                    else
                        ph = PH_DISCHARGE;
                end
            end
            default: begin
                ph = PH_IDLE;
                if (it.start_req) begin
                    tot = '0;
                    if (it.samples == 0) begin
                        r.done_res = 1'b1;
                    end else begin
                        left    = it.samples;
                        raw_lat = it.raw_mode;
                        ph = PH_DISCHARGE;
                    end
                end
            end
        endcase
        if (finish) begin
            r.done_res = 1'b1;
            ph = PH_IDLE;
            if (raw_lat) begin
                r.reading = tot;
            end else begin
                diff = (tot >= base) ? tot - base : base - tot;
                if (ms_cnt > cal_per && diff < base / 10) begin
                    base = COUNT_FULL;
                    cal  = 1'b1;
                end
                if (tot < base)
                    base = tot;
                r.reading = tot - base;
            end
        end
        if (cal)
            ms_cnt = '0;
        else if (it.ms_tick && ms_cnt != '1)
            ms_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // driver: new beat only when the previous one was taken; each beat
    // carries the throttling mode it was queued under
    always @(negedge i_clk) begin
        if (pend_q.size() != 0)
            drv_gap = gap_q[0];
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pend_q.size() != 0 &&
                $urandom_range(99) >= ((drv_gap == GAP_SEND) ? 62 :
                                       (drv_gap == GAP_BOTH) ? 18 : 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pend_q.pop_front();
                drv_gap  = gap_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= $urandom_range(99) >= ((drv_gap == GAP_RECV) ? 62 :
                                           (drv_gap == GAP_BOTH) ? 18 : 0);
    end

    // monitor: check output first, then predict for this edge's input beat
    always @(posedge i_clk) begin : mon
        t_result got;
        t_result want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = t_result'(m_tdata);
                if (reading_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got %h", $time, m_tdata);
                    err_cnt++;
                end else begin
                    want = reading_q.pop_front();
                    check_field("send_level", want.send_level, got.send_level);
                    check_field("recv_drive", want.recv_drive, got.recv_drive);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("status", want.status, got.status);
                    check_field("reading", want.reading, got.reading);
                end
                beats_seen++;
            end
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                sense_step(t_item'(s_tdata), want);
                reading_q.push_back(want);
            end
        end
    end

    task automatic push_item(input bit st, input logic [15:0] ns, input bit rw,
                             input bit lv, input bit tk, input bit rc);
        t_item it;
        it            = '0;
        it.start_req  = st;
        it.samples    = ns;
        it.raw_mode   = rw;
        it.recv_level = lv;
        it.ms_tick    = tk;
        it.recal      = rc;
        pend_q.push_back(it);
        gap_q.push_back(gap_mode);
        beats_queued++;
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_TIMEOUT)
            tmo_lim = val[27:0];
        else
            cal_per = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_random(input int n, input bit big_ok);
        bit          st;
        logic [15:0] ns;
        int          pick;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0)
                gap_mode = $urandom_range(GAP_BOTH);
            if (run_left == 0) begin
                lvl_now  = ~lvl_now;
                run_left = ($urandom_range(9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 10);
            end else begin
                run_left--;
            end
            st   = ($urandom_range(5) == 0);
            pick = $urandom_range(15);
            if (!st)
                ns = $urandom_range(16'hFFFF);
            else if (pick == 0)
                ns = '0;
            else if (pick == 1 && big_ok)
                ns = $urandom_range(16'hFFFF);
            else
                ns = $urandom_range(1, 4);
            push_item(st, ns, $urandom_range(1), lvl_now, $urandom_range(2) == 0,
                      $urandom_range(39) == 0);
        end
    endtask

    // step the timer back to idle one beat at a time; either run the count
    // into the timeout or end every sample at once, whichever is shorter
    task automatic settle_idle();
        bit counting;
        bit lv;
        wait (beats_seen == beats_queued);
        while (ph != PH_IDLE) begin
            counting = (int'(tmo_lim) - int'(tot)) < 4 * int'(left);
            lv = 1'b0;
            if (ph == PH_RISE)
                lv = !counting;
            else if (ph == PH_FALL)
                lv = counting;
            push_item(1'b0, $urandom_range(16'hFFFF), $urandom_range(1), lv,
                      $urandom_range(2) == 0, 1'b0);
            wait (beats_seen == beats_queued);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, no throttling
        gap_mode = GAP_NONE;
        push_item(1'b1, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);   // zero samples
        push_item(1'b1, 16'd1, 1'b1, 1'b0, 1'b0, 1'b0);   // raw, one sample
        push_item(1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0); // start while busy
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b1, 16'd2, 1'b0, 1'b0, 1'b1, 1'b0);   // baseline, two samples
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);   // recal mid-run
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b1, 16'd1, 1'b0, 1'b1, 1'b1, 1'b0);   // empty sample, baseline
        settle_idle();
        add_random(250, 1'b0);
        settle_idle();

        // zero timeout and zero autocal period
        cfg_write(CFG_TIMEOUT, 32'd0);
        cfg_write(CFG_AUTOCAL, 32'd0);
        gap_mode = GAP_SEND;
        push_item(1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1); // all fields high
        push_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        push_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        settle_idle();
        add_random(250, 1'b1);
        settle_idle();

        // largest timeout, autocal never due
        cfg_write(CFG_TIMEOUT, 32'h0FFFFFFF);
        cfg_write(CFG_AUTOCAL, 32'hFFFFFFFF);
        add_random(300, 1'b0);
        settle_idle();

        // short timeout, fast autocal
        cfg_write(CFG_TIMEOUT, 32'd40);
        cfg_write(CFG_AUTOCAL, 32'd3);
        add_random(300, 1'b1);
        settle_idle();

        cfg_write(CFG_TIMEOUT, 32'd300);
        cfg_write(CFG_AUTOCAL, 32'd1);
        add_random(300, 1'b1);
        settle_idle();

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && reading_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
